// ----- rtl/ftpp_pkg.sv -----
`default_nettype none
package ftpp_pkg;

  localparam int NAME_DEPTH_DEF = 256;
  localparam int PACKET_MAX_DEF = 256;

  localparam logic [7:0] SEQ_LAST = 8'd254;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_START_OK = 3'd1;
  localparam logic [2:0] KIND_END_OK   = 3'd2;
  localparam logic [2:0] KIND_END_BAD  = 3'd3;
  localparam logic [2:0] KIND_SEQ_ERR  = 3'd4;

  // packet kinds, as coded in byte 0
  localparam logic [1:0] PK_NONE  = 2'd0;
  localparam logic [1:0] PK_DATA  = 2'd1;
  localparam logic [1:0] PK_START = 2'd2;
  localparam logic [1:0] PK_END   = 2'd3;

  // field parser phases
  localparam logic [1:0] PH_TYPE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  // field types
  localparam logic [7:0] FT_SIZE = 8'd0;
  localparam logic [7:0] FT_NAME = 8'd1;

  // access to the name store issued with one accepted beat
  typedef struct packed {
    logic       wr;    // store a start name byte
    logic       chk;   // compare an end name byte against the store
    logic       clr;   // restart the name comparison
    logic [7:0] addr;
    logic [7:0] data;
  } name_op_t;

endpackage
`default_nettype wire

// ----- rtl/ftpp_name_check.sv -----
`default_nettype none
module ftpp_name_check
  import ftpp_pkg::*;
#(
  parameter int NAME_DEPTH = NAME_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire name_op_t op,
  input  wire logic     retire,
  output logic          mismatch
);

  localparam int AW = $clog2(NAME_DEPTH);

  logic [7:0] name_mem [NAME_DEPTH];
  logic [7:0] rd_data;
  logic [7:0] byte_q;
  logic       chk_q;
  logic       mismatch_reg;
  logic       byte_miss;

  always_ff @(posedge clk) begin
    if (accept && op.wr) begin
      name_mem[op.addr[AW-1:0]] <= op.data;
    end
    if (accept && op.chk) begin
      rd_data <= name_mem[op.addr[AW-1:0]];
    end
    if (accept) begin
      byte_q <= op.data;
    end
  end

  assign byte_miss = chk_q && (rd_data != byte_q);
  assign mismatch  = mismatch_reg | byte_miss;

  // a clear comes from a later beat than the one retiring, so it wins
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_q        <= 1'b0;
      mismatch_reg <= 1'b0;
    end else begin
      if (accept) begin
        chk_q <= op.chk;
      end else if (retire) begin
        chk_q <= 1'b0;
      end
      if (accept && op.clr) begin
        mismatch_reg <= 1'b0;
      end else if (retire && byte_miss) begin
        mismatch_reg <= 1'b1;
      end
    end
  end

  a_no_rw_same_beat: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(op.wr && op.chk))
    else $error("name store written and compared by one beat");

  a_chk_needs_beat: assert property (@(posedge clk) disable iff (rst)
    retire && !accept |=> !chk_q)
    else $error("stale name compare left pending");

  a_clear_wins: assert property (@(posedge clk) disable iff (rst)
    accept && op.clr |=> !mismatch_reg)
    else $error("name mismatch survived a restart");

endmodule
`default_nettype wire

// ----- rtl/file_transfer_packet_parser.sv -----
`default_nettype none
// Receive-side parser for a file transfer protocol. One packet byte enters
// per beat on the s_ side (s_tlast on the final byte) and one beat is taken
// every cycle while the m_ side keeps up. Byte 0 picks the packet kind:
// data packets have their sequence number checked (modulo 255) and their
// payload bytes passed out one per beat; start and end packets are parsed
// as type-length-value fields and report once at their last byte, the end
// packet checked against the stored start size and name. A sequence error
// is reported once and then the block ignores all input until reset. A
// result passes from its taken byte through the compare stage, which waits
// for the registered name store read, then the output register to the m_ side.
// The file name lives in a NAME_DEPTH-byte memory that needs no clearing.
module file_transfer_packet_parser
  import ftpp_pkg::*;
#(
  parameter int NAME_DEPTH = NAME_DEPTH_DEF,
  parameter int PACKET_MAX = PACKET_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // pkt_byte
  input  wire logic        s_tlast,   // pkt_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // data_byte, file_size, name_length, received_total
  output logic             m_tlast,   // payload_last
  output logic [2:0]       m_tuser    // kind
);

  localparam int PW = $clog2(PACKET_MAX + 1);
  localparam logic [PW-1:0] POS_MAX  = PW'(PACKET_MAX);
  localparam logic [PW-1:0] POS_SEQ  = PW'(1);
  localparam logic [PW-1:0] POS_LENH = PW'(2);
  localparam logic [PW-1:0] POS_LENL = PW'(3);
  localparam logic [8:0]    NAME_LIM = 9'(NAME_DEPTH);

  // parser state
  logic          halted, halted_next;
  logic [7:0]    expected_seq, expected_seq_next;
  logic [PW-1:0] byte_position, byte_position_next;
  logic [1:0]    packet_kind, packet_kind_next;
  logic [1:0]    field_phase, field_phase_next;
  logic          field_type, field_type_next;
  logic [7:0]    field_remaining, field_remaining_next;
  logic [15:0]   payload_length, payload_length_next;
  logic [15:0]   payload_count, payload_count_next;
  logic [31:0]   start_size, start_size_next;
  logic [31:0]   current_size, current_size_next;
  logic [7:0]    start_name_length, start_name_length_next;
  logic [7:0]    current_name_length, current_name_length_next;
  logic [31:0]   total_bytes, total_bytes_next;

  // result of the beat being parsed
  logic          r_valid;
  logic [2:0]    r_kind;
  logic [7:0]    r_data;
  logic          r_last;
  logic [31:0]   r_size;
  logic [7:0]    r_nlen;
  logic          r_endchk;
  logic          r_base_ok;
  name_op_t      op;
  logic          seq_err;
  logic [7:0]    k;

  // compare stage
  logic          b_valid, b_res, b_endchk, b_base_ok, b_last;
  logic [2:0]    b_kind;
  logic [7:0]    b_data, b_nlen;
  logic [31:0]   b_size, b_total;
  logic          b_fire;
  logic          out_adv;
  logic          accept;
  logic          mismatch;
  logic [2:0]    b_kind_final;

  // output register
  logic [2:0]    o_kind;
  logic [7:0]    o_data, o_nlen;
  logic          o_last;
  logic [31:0]   o_size, o_total;

  assign out_adv  = !m_tvalid || m_tready;
  assign b_fire   = b_valid && (!b_res || out_adv);
  assign s_tready = !b_valid || b_fire;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    halted_next              = halted;
    expected_seq_next        = expected_seq;
    byte_position_next       = byte_position;
    packet_kind_next         = packet_kind;
    field_phase_next         = field_phase;
    field_type_next          = field_type;
    field_remaining_next     = field_remaining;
    payload_length_next      = payload_length;
    payload_count_next       = payload_count;
    start_size_next          = start_size;
    current_size_next        = current_size;
    start_name_length_next   = start_name_length;
    current_name_length_next = current_name_length;
    total_bytes_next         = total_bytes;
    r_valid   = 1'b0;
    r_kind    = KIND_PAYLOAD;
    r_data    = 8'd0;
    r_last    = 1'b0;
    r_size    = 32'd0;
    r_nlen    = 8'd0;
    r_endchk  = 1'b0;
    r_base_ok = 1'b0;
    op.wr     = 1'b0;
    op.chk    = 1'b0;
    op.clr    = 1'b0;
    op.addr   = current_name_length;
    op.data   = s_tdata;
    seq_err   = 1'b0;
    k         = field_remaining - 8'd1;

    if (!halted) begin
      if (byte_position == '0) begin
        if (s_tdata == 8'd1) begin
          packet_kind_next = PK_DATA;
        end else if (s_tdata == 8'd2) begin
          packet_kind_next = PK_START;
        end else if (s_tdata == 8'd3) begin
          packet_kind_next = PK_END;
        end else begin
          packet_kind_next = PK_NONE;
        end
        if (packet_kind_next == PK_START || packet_kind_next == PK_END) begin
          field_phase_next         = PH_TYPE;
          field_type_next          = 1'b0;
          field_remaining_next     = 8'd0;
          current_size_next        = 32'd0;
          current_name_length_next =
            (packet_kind_next == PK_START) ? start_name_length : 8'd0;
          op.clr = 1'b1;
        end
      end else if (byte_position < POS_MAX) begin
        if (packet_kind == PK_DATA) begin
          if (byte_position == POS_SEQ) begin
            if (s_tdata != expected_seq) begin
              // report once, then ignore everything until reset
              seq_err            = 1'b1;
              halted_next        = 1'b1;
              byte_position_next = '0;
              packet_kind_next   = PK_NONE;
              r_valid            = 1'b1;
              r_kind             = KIND_SEQ_ERR;
              r_size             = 32'd0;
            end else begin
              expected_seq_next = (expected_seq == SEQ_LAST) ? 8'd0
                                                              : expected_seq + 8'd1;
            end
          end else if (byte_position == POS_LENH) begin
            payload_length_next = {s_tdata, 8'd0};
          end else if (byte_position == POS_LENL) begin
            payload_length_next = {payload_length[15:8], s_tdata};
            payload_count_next  = 16'd0;
          end else if (payload_count < payload_length) begin
            payload_count_next = payload_count + 16'd1;
            if (total_bytes != 32'hFFFF_FFFF) begin
              total_bytes_next = total_bytes + 32'd1;
            end
            r_valid = 1'b1;
            r_kind  = KIND_PAYLOAD;
            r_data  = s_tdata;
            r_last  = (payload_count_next == payload_length);
          end
        end else if (packet_kind != PK_NONE) begin
          unique case (field_phase)
            PH_TYPE: begin
              if (s_tdata == FT_SIZE || s_tdata == FT_NAME) begin
                field_type_next  = s_tdata[0];
                field_phase_next = PH_LEN;
              end
            end
            PH_LEN: begin
              if (s_tdata == 8'd0) begin
                field_phase_next = PH_TYPE;
              end else begin
                field_remaining_next = s_tdata;
                field_phase_next     = PH_VALUE;
                if (field_type) begin
                  current_name_length_next = 8'd0;
                  op.clr                   = 1'b1;
                end
              end
            end
            default: begin
              if (!field_type) begin
                // drop size bytes of 2^32 weight and above
                if (k < 8'd4) begin
                  current_size_next = current_size +
                                      ({24'd0, s_tdata} << {k[1:0], 3'b000});
                end
              end else begin
                if ({1'b0, current_name_length} < NAME_LIM) begin
                  if (packet_kind == PK_START) begin
                    op.wr = 1'b1;
                  end else if (current_name_length < start_name_length) begin
                    op.chk = 1'b1;
                  end
                end
                current_name_length_next = current_name_length + 8'd1;
              end
              field_remaining_next = field_remaining - 8'd1;
              if (field_remaining_next == 8'd0) begin
                field_phase_next = PH_TYPE;
              end
            end
          endcase
        end
      end

      if (!seq_err) begin
        if (s_tlast) begin
          if (packet_kind_next == PK_START) begin
            start_size_next        = current_size_next;
            start_name_length_next = current_name_length_next;
            r_valid = 1'b1;
            r_kind  = KIND_START_OK;
            r_data  = 8'd0;
            r_last  = 1'b0;
            r_size  = current_size_next;
            r_nlen  = current_name_length_next;
          end else if (packet_kind_next == PK_END) begin
            r_valid   = 1'b1;
            r_endchk  = 1'b1;
            r_base_ok = (current_size_next == start_size) &&
                        (current_name_length_next == start_name_length);
            r_kind    = KIND_END_BAD;
            r_data    = 8'd0;
            r_last    = 1'b0;
            r_size    = current_size_next;
            r_nlen    = current_name_length_next;
          end
          byte_position_next = '0;
          packet_kind_next   = PK_NONE;
        end else if (byte_position < POS_MAX) begin
          byte_position_next = byte_position + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted              <= 1'b0;
      expected_seq        <= 8'd0;
      byte_position       <= '0;
      packet_kind         <= PK_NONE;
      field_phase         <= PH_TYPE;
      field_type          <= 1'b0;
      field_remaining     <= 8'd0;
      payload_length      <= 16'd0;
      payload_count       <= 16'd0;
      start_size          <= 32'd0;
      current_size        <= 32'd0;
      start_name_length   <= 8'd0;
      current_name_length <= 8'd0;
      total_bytes         <= 32'd0;
    end else if (accept) begin
      halted              <= halted_next;
      expected_seq        <= expected_seq_next;
      byte_position       <= byte_position_next;
      packet_kind         <= packet_kind_next;
      field_phase         <= field_phase_next;
      field_type          <= field_type_next;
      field_remaining     <= field_remaining_next;
      payload_length      <= payload_length_next;
      payload_count       <= payload_count_next;
      start_size          <= start_size_next;
      current_size        <= current_size_next;
      start_name_length   <= start_name_length_next;
      current_name_length <= current_name_length_next;
      total_bytes         <= total_bytes_next;
    end
  end

  ftpp_name_check #(
    .NAME_DEPTH (NAME_DEPTH)
  ) u_name_check (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (op),
    .retire   (b_fire),
    .mismatch (mismatch)
  );

  // compare stage: waits for the name store read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_res     <= r_valid;
      b_endchk  <= r_endchk;
      b_base_ok <= r_base_ok;
      b_kind    <= r_kind;
      b_data    <= r_data;
      b_last    <= r_last;
      b_size    <= r_size;
      b_nlen    <= r_nlen;
      b_total   <= total_bytes_next;
    end
  end

  assign b_kind_final = b_endchk ? ((b_base_ok && !mismatch) ? KIND_END_OK : KIND_END_BAD)
                                 : b_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_fire && b_res) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_res) begin
      o_kind  <= b_kind_final;
      o_data  <= b_data;
      o_last  <= b_last;
      o_size  <= b_size;
      o_nlen  <= b_nlen;
      o_total <= b_total;
    end
  end

  assign m_tuser = o_kind;
  assign m_tlast = o_last;
  assign m_tdata = {o_total, o_nlen, o_size, o_data};

  a_seq_err_halts: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_res && b_kind == KIND_SEQ_ERR |-> halted)
    else $error("sequence error reported without halting");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    halted && accept |=> !b_res)
    else $error("result produced while halted");

  a_seq_range: assert property (@(posedge clk) disable iff (rst)
    expected_seq <= SEQ_LAST)
    else $error("expected sequence number out of range");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_res && b_kind == KIND_PAYLOAD && !b_endchk
      |-> b_size == 32'd0 && b_nlen == 8'd0)
    else $error("payload beat carries control fields");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_MAX)
    else $error("byte position past packet limit");

endmodule
`default_nettype wire
